// ===== rtl/core/odgpio_pkg.sv =====
// Shared types and register map constants for the open-drain GPIO bank.
`default_nettype none

package odgpio_pkg;

  // Kind of item on the input channel (travels in tuser).
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_EVENT = 2'd2
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STRAP_VALUE  = 1'b0,
    CFG_STRAP_OFFSET = 1'b1
  } cfg_index_t;

  localparam int unsigned OFFSET_W     = 12;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned PIN_IDX_W    = 6;
  localparam int unsigned IN_TDATA_W   = 56;  // 51 payload bits padded to bytes

  localparam logic [OFFSET_W-1:0] STRAP_OFFSET_RESET = 12'h038;

  // Register window byte offsets.
  localparam logic [OFFSET_W-1:0] OFS_OUT         = 12'h004;
  localparam logic [OFFSET_W-1:0] OFS_OUT_SET     = 12'h008;
  localparam logic [OFFSET_W-1:0] OFS_OUT_CLR     = 12'h00c;
  localparam logic [OFFSET_W-1:0] OFS_OUT1        = 12'h010;
  localparam logic [OFFSET_W-1:0] OFS_OUT1_SET    = 12'h014;
  localparam logic [OFFSET_W-1:0] OFS_OUT1_CLR    = 12'h018;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE      = 12'h020;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE_SET  = 12'h024;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE_CLR  = 12'h028;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE1     = 12'h02c;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE1_SET = 12'h030;
  localparam logic [OFFSET_W-1:0] OFS_ENABLE1_CLR = 12'h034;
  localparam logic [OFFSET_W-1:0] OFS_IN          = 12'h03c;
  localparam logic [OFFSET_W-1:0] OFS_IN1         = 12'h040;

endpackage

`default_nettype wire

// ===== rtl/core/open_drain_gpio_bank.sv =====
// Top level of the open-drain GPIO bank: register window, pin state and result register.
//
// Usage:
//  - Input channel s_*: one item per accepted beat. tuser carries the item kind
//    (bus read, bus write, external pin event); tdata carries offset, write
//    data, pin index and pin level.
//  - Output channel m_*: exactly one result item per input item, in order.
//    tdata carries the read word (0 for anything but a known read) and the
//    driven level of every pin after the item.
//  - Configuration: cfg_we writes cfg_data into the strap value (index 0) or
//    the strap offset (index 1) at the clock edge. Write only while idle.
//  - The result appears in the cycle after the item is accepted; all
//    work is one pass of logic from the state registers into the result
//    register. Throughput: one item per cycle while the receiver takes them.
//  - Stall: s_tready drops while a result sits in the output register and
//    the receiver holds m_tready low; the held result stays unchanged.
//  - Reset (rst, synchronous): output and enable registers clear, external
//    levels go all high, strap value clears, strap offset returns to 0x38,
//    and the output register empties.
`default_nettype none

module open_drain_gpio_bank #(
  parameter int unsigned PIN_COUNT = 54
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // config write port
  input  wire logic                                  cfg_we,
  input  wire logic [0:0]                            cfg_index,
  input  wire logic [odgpio_pkg::WORD_W-1:0]         cfg_data,
  // input items
  input  wire logic                                  s_tvalid,
  output      logic                                  s_tready,
  // [11:0] reg_offset, [43:12] write_data, [49:44] pin_index, [50] pin_level
  input  wire logic [odgpio_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                            s_tuser,
  // result items
  output      logic                                  m_tvalid,
  input  wire logic                                  m_tready,
  // [31:0] read_data, [PIN_COUNT+31:32] line_levels, zero pad above
  output      logic [((32 + PIN_COUNT + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned HIGH_BITS  = PIN_COUNT - 32;
  localparam int unsigned OUT_W      = ((32 + PIN_COUNT + 7) / 8) * 8;
  localparam int unsigned PIN_CMP_W  = odgpio_pkg::PIN_IDX_W + 1;
  localparam logic [PIN_CMP_W-1:0] PIN_LIMIT = PIN_CMP_W'(PIN_COUNT);

  // Configuration
  logic [31:0] strap_value;
  logic [11:0] strap_offset;

  // Pin state
  logic [31:0]          out_low_bank;
  logic [HIGH_BITS-1:0] out_high_bank;
  logic [31:0]          enable_low_bank;
  logic [HIGH_BITS-1:0] enable_high_bank;
  logic [31:0]          external_low_bank;
  logic [HIGH_BITS-1:0] external_high_bank;

  logic [31:0]          out_low_bank_next;
  logic [HIGH_BITS-1:0] out_high_bank_next;
  logic [31:0]          enable_low_bank_next;
  logic [HIGH_BITS-1:0] enable_high_bank_next;
  logic [31:0]          external_low_bank_next;
  logic [HIGH_BITS-1:0] external_high_bank_next;

  // Input fields
  logic [11:0]          reg_offset;
  logic [31:0]          write_data;
  logic [5:0]           pin_index;
  logic                 pin_level;
  logic [HIGH_BITS-1:0] write_high;
  logic [31:0]          pin_bit;
  logic                 pin_valid;
  logic                 pin_high;

  logic [31:0]          read_data;
  logic [31:0]          in_low_view;
  logic [HIGH_BITS-1:0] in_high_view;
  logic [31:0]          lines_low;
  logic [HIGH_BITS-1:0] lines_high;
  logic                 accept;

  assign reg_offset = s_tdata[11:0];
  assign write_data = s_tdata[43:12];
  assign pin_index  = s_tdata[49:44];
  assign pin_level  = s_tdata[50];
  assign write_high = write_data[HIGH_BITS-1:0];

  // One output register: take a new item whenever the slot is empty or drains now.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Wired-AND input view: an enabled pin driving 0 reads 0.
  assign in_low_view  = external_low_bank & ~(enable_low_bank & ~out_low_bank);
  assign in_high_view = external_high_bank & ~(enable_high_bank & ~out_high_bank);

  assign pin_bit   = 32'd1 << pin_index[4:0];
  assign pin_valid = {1'b0, pin_index} < PIN_LIMIT;
  assign pin_high  = pin_index[5];

  // Bus read mux; fixed registers win over the strap on an offset collision.
  always_comb begin
    read_data = '0;
    if (s_tuser == odgpio_pkg::REQ_READ) begin
      case (reg_offset)
        odgpio_pkg::OFS_OUT:     read_data = out_low_bank;
        odgpio_pkg::OFS_OUT1:    read_data = 32'(out_high_bank);
        odgpio_pkg::OFS_ENABLE:  read_data = enable_low_bank;
        odgpio_pkg::OFS_ENABLE1: read_data = 32'(enable_high_bank);
        odgpio_pkg::OFS_IN:      read_data = in_low_view;
        odgpio_pkg::OFS_IN1:     read_data = 32'(in_high_view);
        default: begin
          if (reg_offset == strap_offset) begin
            read_data = strap_value;
          end
        end
      endcase
    end
  end

  // State update for writes and pin events.
  always_comb begin
    out_low_bank_next       = out_low_bank;
    out_high_bank_next      = out_high_bank;
    enable_low_bank_next    = enable_low_bank;
    enable_high_bank_next   = enable_high_bank;
    external_low_bank_next  = external_low_bank;
    external_high_bank_next = external_high_bank;
    case (s_tuser)
      odgpio_pkg::REQ_WRITE: begin
        case (reg_offset)
          odgpio_pkg::OFS_OUT:         out_low_bank_next     = write_data;
          odgpio_pkg::OFS_OUT_SET:     out_low_bank_next     = out_low_bank | write_data;
          odgpio_pkg::OFS_OUT_CLR:     out_low_bank_next     = out_low_bank & ~write_data;
          odgpio_pkg::OFS_OUT1:        out_high_bank_next    = write_high;
          odgpio_pkg::OFS_OUT1_SET:    out_high_bank_next    = out_high_bank | write_high;
          odgpio_pkg::OFS_OUT1_CLR:    out_high_bank_next    = out_high_bank & ~write_high;
          odgpio_pkg::OFS_ENABLE:      enable_low_bank_next  = write_data;
          odgpio_pkg::OFS_ENABLE_SET:  enable_low_bank_next  = enable_low_bank | write_data;
          odgpio_pkg::OFS_ENABLE_CLR:  enable_low_bank_next  = enable_low_bank & ~write_data;
          odgpio_pkg::OFS_ENABLE1:     enable_high_bank_next = write_high;
          odgpio_pkg::OFS_ENABLE1_SET: enable_high_bank_next = enable_high_bank | write_high;
          odgpio_pkg::OFS_ENABLE1_CLR: enable_high_bank_next = enable_high_bank & ~write_high;
          default: ;
        endcase
      end
      odgpio_pkg::REQ_EVENT: begin
        if (pin_valid && !pin_high) begin
          external_low_bank_next = pin_level ? (external_low_bank | pin_bit)
                                             : (external_low_bank & ~pin_bit);
        end else if (pin_valid) begin
          // pin_valid keeps the bit position inside the high bank
          external_high_bank_next = pin_level
                                  ? (external_high_bank | pin_bit[HIGH_BITS-1:0])
                                  : (external_high_bank & ~pin_bit[HIGH_BITS-1:0]);
        end
      end
      default: ;
    endcase
  end

  // Driven levels after this item.
  assign lines_low  = ~(enable_low_bank_next & ~out_low_bank_next);
  assign lines_high = ~(enable_high_bank_next & ~out_high_bank_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      strap_value  <= '0;
      strap_offset <= odgpio_pkg::STRAP_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        odgpio_pkg::CFG_STRAP_VALUE:  strap_value  <= cfg_data;
        odgpio_pkg::CFG_STRAP_OFFSET: strap_offset <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_low_bank       <= '0;
      out_high_bank      <= '0;
      enable_low_bank    <= '0;
      enable_high_bank   <= '0;
      external_low_bank  <= '1;
      external_high_bank <= '1;
    end else if (accept) begin
      out_low_bank       <= out_low_bank_next;
      out_high_bank      <= out_high_bank_next;
      enable_low_bank    <= enable_low_bank_next;
      enable_high_bank   <= enable_high_bank_next;
      external_low_bank  <= external_low_bank_next;
      external_high_bank <= external_high_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_W'({lines_high, lines_low, read_data});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/odgpio_checker.sv =====
// Port-level checker for the open-drain GPIO bank, bound to the top level.
`default_nettype none

module odgpio_checker #(
  parameter int unsigned PIN_COUNT = 54
) (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_tvalid,
  input wire logic                                  s_tready,
  input wire logic [1:0]                            s_tuser,
  input wire logic                                  m_tvalid,
  input wire logic                                  m_tready,
  input wire logic [((32 + PIN_COUNT + 7) / 8) * 8 - 1:0] m_tdata
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Every accepted item yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted item produced no result");

  // Writes, events and unknown kinds return a zero read word.
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != odgpio_pkg::REQ_READ) |=> (m_tdata[31:0] == 32'd0))
    else $error("nonzero read word for a non-read item");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind open_drain_gpio_bank odgpio_checker #(.PIN_COUNT(PIN_COUNT)) u_odgpio_checker (.*);

`default_nettype wire
